### design/svv_pkg.sv
`timescale 1ns / 1ps

package svv_pkg;

   // Parser phases, one-hot.
   typedef enum logic [5:0] {
      PH_MAJOR = 6'b000001,
      PH_MINOR = 6'b000010,
      PH_PATCH = 6'b000100,
      PH_PRE   = 6'b001000,
      PH_BUILD = 6'b010000,
      PH_FAIL  = 6'b100000
   } svv_phase_type;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [7:0] CH_LOW_A = 8'h61;
   localparam logic [7:0] CH_LOW_Z = 8'h7A;

   typedef struct packed {
      svv_phase_type phase;
      logic [31:0]   num_accum;
      logic          num_seen_digit;
      logic          num_first_zero;
      logic [31:0]   major_hold;
      logic [31:0]   minor_hold;
      logic          ident_nonempty;
      logic          ident_longer_one;
      logic          ident_zero_lead;
      logic          ident_all_digits;
      logic          pre_seen;
   } svv_state_type;

   typedef struct packed {
      logic        is_valid;
      logic [31:0] major_num;
      logic [31:0] minor_num;
      logic [31:0] patch_num;
      logic        has_prerelease;
      logic        has_build;
   } svv_result_type;

   localparam svv_state_type SVV_STATE_RESET = '{
      phase:            PH_MAJOR,
      num_accum:        32'd0,
      num_seen_digit:   1'b0,
      num_first_zero:   1'b0,
      major_hold:       32'd0,
      minor_hold:       32'd0,
      ident_nonempty:   1'b0,
      ident_longer_one: 1'b0,
      ident_zero_lead:  1'b0,
      ident_all_digits: 1'b1,
      pre_seen:         1'b0
   };

endpackage

### design/svv_req_if.sv
`timescale 1ns / 1ps

interface svv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;

   modport source (output valid, output char_byte, input ready);
   modport sink (input valid, input char_byte, output ready);
endinterface

### design/svv_rsp_if.sv
`timescale 1ns / 1ps

interface svv_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_valid;
   logic [31:0] major_num;
   logic [31:0] minor_num;
   logic [31:0] patch_num;
   logic        has_prerelease;
   logic        has_build;

   modport source (output valid, output is_valid, output major_num, output minor_num,
                   output patch_num, output has_prerelease, output has_build, input ready);
   modport sink (input valid, input is_valid, input major_num, input minor_num,
                 input patch_num, input has_prerelease, input has_build, output ready);
endinterface

### design/svv_step.sv
`timescale 1ns / 1ps

// One parser step: folds one byte into the parse state.
module svv_step
   import svv_pkg::*;
(
   input  svv_state_type  cur_state,
   input  logic [7:0]     char_byte,
   output svv_state_type  nxt_state,
   output logic           is_end,
   output svv_result_type result
);

   svv_state_type s;
   logic          ok;
   logic          is_digit;
   logic          is_ident;
   logic          is_sep;
   logic          close_ok;
   logic [35:0]   acc_ext;
   logic [35:0]   acc_x10;

   assign is_end   = (char_byte == CH_NUL);
   assign is_digit = char_byte inside {[CH_ZERO:CH_NINE]};
   assign is_ident = is_digit || (char_byte inside {[CH_UP_A:CH_UP_Z], [CH_LOW_A:CH_LOW_Z]})
                     || (char_byte == CH_DASH);

   // Multiply by ten as two shifts and an add, plus the new digit.
   assign acc_ext = {4'b0000, cur_state.num_accum};
   assign acc_x10 = (acc_ext << 3) + (acc_ext << 1) + {32'd0, char_byte[3:0]};

   always_comb begin
      s        = cur_state;
      ok       = 1'b1;
      is_sep   = 1'b0;
      close_ok = 1'b0;

      case (cur_state.phase)
         PH_MAJOR, PH_MINOR, PH_PATCH: begin
            if (is_digit) begin
               if (!cur_state.num_seen_digit) begin
                  s.num_seen_digit = 1'b1;
                  s.num_first_zero = (char_byte == CH_ZERO);
                  s.num_accum      = {28'd0, char_byte[3:0]};
               end else if (cur_state.num_first_zero) begin
                  ok = 1'b0;
               end else if (acc_x10[35:32] != 4'd0) begin
                  ok = 1'b0;
               end else begin
                  s.num_accum = acc_x10[31:0];
               end
            end else if (!cur_state.num_seen_digit) begin
               ok = 1'b0;
            end else if (cur_state.phase == PH_PATCH) begin
               if (char_byte == CH_DASH) begin
                  s.pre_seen = 1'b1;
                  s.phase    = PH_PRE;
               end else if (char_byte == CH_PLUS) begin
                  s.phase = PH_BUILD;
               end else if (!is_end) begin
                  ok = 1'b0;
               end
            end else if (char_byte == CH_DOT) begin
               if (cur_state.phase == PH_MAJOR) begin
                  s.major_hold = cur_state.num_accum;
                  s.phase      = PH_MINOR;
               end else begin
                  s.minor_hold = cur_state.num_accum;
                  s.phase      = PH_PATCH;
               end
               s.num_accum      = 32'd0;
               s.num_seen_digit = 1'b0;
               s.num_first_zero = 1'b0;
            end else begin
               ok = 1'b0;
            end
         end
         PH_PRE, PH_BUILD: begin
            if (cur_state.phase == PH_PRE) begin
               is_sep = (char_byte == CH_DOT) || (char_byte == CH_PLUS) || is_end;
            end else begin
               is_sep = (char_byte == CH_DOT) || is_end;
            end
            if (is_sep) begin
               // The numeric no-leading-zero rule applies to pre-release only.
               close_ok = cur_state.ident_nonempty &&
                          !((cur_state.phase == PH_PRE) && cur_state.ident_all_digits &&
                            cur_state.ident_longer_one && cur_state.ident_zero_lead);
               ok = close_ok;
               s.ident_nonempty   = 1'b0;
               s.ident_longer_one = 1'b0;
               s.ident_zero_lead  = 1'b0;
               s.ident_all_digits = 1'b1;
               if (close_ok && (char_byte == CH_PLUS)) begin
                  s.phase = PH_BUILD;
               end
            end else if (is_ident) begin
               if (!cur_state.ident_nonempty) begin
                  s.ident_nonempty  = 1'b1;
                  s.ident_zero_lead = (char_byte == CH_ZERO);
               end else begin
                  s.ident_longer_one = 1'b1;
               end
               if (!is_digit) begin
                  s.ident_all_digits = 1'b0;
               end
            end else begin
               ok = 1'b0;
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase

      if (!ok) begin
         s.phase = PH_FAIL;
      end

      if (s.phase == PH_FAIL) begin
         result = '0;
      end else begin
         result.is_valid       = 1'b1;
         result.major_num      = s.major_hold;
         result.minor_num      = s.minor_hold;
         result.patch_num      = s.num_accum;
         result.has_prerelease = s.pre_seen;
         result.has_build      = (s.phase == PH_BUILD);
      end

      // The end of a string returns the parser to its starting state.
      nxt_state = is_end ? SVV_STATE_RESET : s;
   end

endmodule

### design/semver_string_validator.sv
`timescale 1ns / 1ps

// Semantic version string checker.
// The req channel carries one word per string byte; a zero byte ends the
// string. For each zero byte the rsp channel gives one word: is_valid, the
// major, minor and patch numbers and the pre-release and build flags. An
// invalid string gives all fields zero. Other bytes give no result.
// A byte is taken into an input register, then one parser step updates the
// parse state and, at a zero byte, loads the result register, which drives
// rsp_ch.valid. One byte is accepted every cycle while no result waits on a
// stalled receiver; the rate is set by the combinational multiply-by-ten
// step of the number accumulator.
// When the receiver stalls with a result waiting, req_ch.ready drops and the
// whole pipe holds; it moves again in the cycle the result is taken.
// Reset empties both registers and returns the parser to the start of a
// string; the first byte may be sent in the cycle after reset is released.
module semver_string_validator
   import svv_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   svv_req_if.sink         req_ch,
   svv_rsp_if.source       rsp_ch
);

   logic           advance;
   logic           in_valid_ff;
   logic [7:0]     in_byte_ff;
   svv_state_type  state_ff;
   svv_state_type  state_in;
   logic           step_end;
   svv_result_type step_result;
   logic           rsp_valid_ff;
   svv_result_type rsp_data_ff;

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   svv_step u_step (
      .cur_state (state_ff),
      .char_byte (in_byte_ff),
      .nxt_state (state_in),
      .is_end    (step_end),
      .result    (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= SVV_STATE_RESET;
      end else if (advance) begin
         in_valid_ff  <= req_ch.valid;
         rsp_valid_ff <= in_valid_ff && step_end;
         if (in_valid_ff) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_byte_ff <= req_ch.char_byte;
         if (in_valid_ff && step_end) begin
            rsp_data_ff <= step_result;
         end
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.is_valid       = rsp_data_ff.is_valid;
   assign rsp_ch.major_num      = rsp_data_ff.major_num;
   assign rsp_ch.minor_num      = rsp_data_ff.minor_num;
   assign rsp_ch.patch_num      = rsp_data_ff.patch_num;
   assign rsp_ch.has_prerelease = rsp_data_ff.has_prerelease;
   assign rsp_ch.has_build      = rsp_data_ff.has_build;

endmodule

### design/svv_checker.sv
`timescale 1ns / 1ps

module svv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_is_valid,
   input logic [31:0] rsp_major_num,
   input logic [31:0] rsp_minor_num,
   input logic [31:0] rsp_patch_num,
   input logic        rsp_has_prerelease,
   input logic        rsp_has_build
);

   // A failed string shows no numbers and no flags.
   a_invalid_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_valid |->
         rsp_major_num == 32'd0 && rsp_minor_num == 32'd0 && rsp_patch_num == 32'd0 &&
         !rsp_has_prerelease && !rsp_has_build)
      else $error("invalid result carries nonzero fields");

   // Bytes are refused only while a result waits on a stalled receiver.
   a_ready_backpressure: assert property (@(posedge clock)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output back-pressure");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_is_valid) &&
         $stable(rsp_major_num) && $stable(rsp_minor_num) && $stable(rsp_patch_num) &&
         $stable(rsp_has_prerelease) && $stable(rsp_has_build))
      else $error("stalled result word changed");

endmodule

bind semver_string_validator svv_checker u_svv_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_is_valid       (rsp_ch.is_valid),
   .rsp_major_num      (rsp_ch.major_num),
   .rsp_minor_num      (rsp_ch.minor_num),
   .rsp_patch_num      (rsp_ch.patch_num),
   .rsp_has_prerelease (rsp_ch.has_prerelease),
   .rsp_has_build      (rsp_ch.has_build)
);

### tb/sv/semver_result_checker.sv
`timescale 1ns / 1ps

module semver_result_checker
   import svv_pkg::*;
(
   input  logic clock,
   input  logic reset,
   svv_req_if   req_mon,
   svv_rsp_if   rsp_mon,
   output int   mismatches,
   output int   verdicts_waiting,
   output int   verdicts_seen,
   output int   valid_seen
);

   // Parse state, kept as the block keeps it.
   svv_phase_type  ph;
   logic [63:0]    num_value;
   bit             num_has_digit;
   bit             num_lead_zero;
   logic [31:0]    major_kept;
   logic [31:0]    minor_kept;
   bit             id_nonempty;
   bit             id_longer;
   bit             id_zero_lead;
   bit             id_all_digits;
   bit             pre_open;

   svv_result_type verdict_queue[$];

   function automatic bit is_digit_byte(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic bit is_ident_byte(input logic [7:0] c);
      return is_digit_byte(c) || (c >= CH_UP_A && c <= CH_UP_Z) ||
             (c >= CH_LOW_A && c <= CH_LOW_Z) || c == CH_DASH;
   endfunction

   function void clear_number();
      num_value = '0;
      num_has_digit = 1'b0;
      num_lead_zero = 1'b0;
   endfunction

   function void clear_ident();
      id_nonempty = 1'b0;
      id_longer = 1'b0;
      id_zero_lead = 1'b0;
      id_all_digits = 1'b1;
   endfunction

   function void clear_parse();
      ph = PH_MAJOR;
      clear_number();
      major_kept = '0;
      minor_kept = '0;
      clear_ident();
      pre_open = 1'b0;
   endfunction

   // Adds one decimal digit; a leading zero or a value past 32 bits refuses it.
   function bit add_digit(input logic [7:0] c);
      logic [63:0] d;
      d = 64'(c) - 64'(CH_ZERO);
      if (!num_has_digit) begin
         num_has_digit = 1'b1;
         num_lead_zero = (d == 64'd0);
         num_value = d;
         return 1'b1;
      end
      if (num_lead_zero)
         return 1'b0;
      num_value = num_value * 64'd10 + d;
      return num_value <= 64'h0000_0000_FFFF_FFFF;
   endfunction

   function void add_ident_byte(input logic [7:0] c);
      if (!id_nonempty) begin
         id_nonempty = 1'b1;
         id_zero_lead = (c == CH_ZERO);
      end else begin
         id_longer = 1'b1;
      end
      if (!is_digit_byte(c))
         id_all_digits = 1'b0;
   endfunction

   function bit close_ident(input bit numeric_rule);
      bit ok;
      ok = id_nonempty;
      if (numeric_rule && id_all_digits && id_longer && id_zero_lead)
         ok = 1'b0;
      clear_ident();
      return ok;
   endfunction

   // Advances the parse by one byte; returns 1 with the verdict at a zero byte.
   function bit advance_parse(input logic [7:0] c, output svv_result_type verdict);
      bit ok;
      ok = 1'b1;
      verdict = '0;
      case (ph)
         PH_MAJOR, PH_MINOR: begin
            if (is_digit_byte(c)) begin
               ok = add_digit(c);
            end else if (c == CH_DOT && num_has_digit) begin
               if (ph == PH_MAJOR) begin
                  major_kept = num_value[31:0];
                  ph = PH_MINOR;
               end else begin
                  minor_kept = num_value[31:0];
                  ph = PH_PATCH;
               end
               clear_number();
            end else begin
               ok = 1'b0;
            end
         end
         PH_PATCH: begin
            if (is_digit_byte(c)) begin
               ok = add_digit(c);
            end else if (!num_has_digit) begin
               ok = 1'b0;
            end else if (c == CH_DASH) begin
               pre_open = 1'b1;
               clear_ident();
               ph = PH_PRE;
            end else if (c == CH_PLUS) begin
               clear_ident();
               ph = PH_BUILD;
            end else if (c != CH_NUL) begin
               ok = 1'b0;
            end
         end
         PH_PRE: begin
            if (c == CH_DOT || c == CH_PLUS || c == CH_NUL) begin
               ok = close_ident(1'b1);
               if (ok && c == CH_PLUS)
                  ph = PH_BUILD;
            end else if (is_ident_byte(c)) begin
               add_ident_byte(c);
            end else begin
               ok = 1'b0;
            end
         end
         PH_BUILD: begin
            if (c == CH_DOT || c == CH_NUL) begin
               ok = close_ident(1'b0);
            end else if (is_ident_byte(c)) begin
               add_ident_byte(c);
            end else begin
               ok = 1'b0;
            end
         end
         default: begin
            ph = PH_FAIL;
         end
      endcase
      if (!ok)
         ph = PH_FAIL;
      if (c != CH_NUL)
         return 1'b0;
      if (ph != PH_FAIL) begin
         verdict.is_valid = 1'b1;
         verdict.major_num = major_kept;
         verdict.minor_num = minor_kept;
         verdict.patch_num = num_value[31:0];
         verdict.has_prerelease = pre_open;
         verdict.has_build = (ph == PH_BUILD);
      end
      clear_parse();
      return 1'b1;
   endfunction

   function void check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
         mismatches++;
      end
   endfunction

   initial begin
      clear_parse();
      mismatches = 0;
      verdicts_waiting = 0;
      verdicts_seen = 0;
      valid_seen = 0;
   end

   always @(posedge clock) begin
      svv_result_type fresh;
      svv_result_type want;
      if (reset) begin
         clear_parse();
         verdict_queue.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            if (advance_parse(req_mon.char_byte, fresh))
               verdict_queue.push_back(fresh);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            verdicts_seen++;
            if (rsp_mon.is_valid === 1'b1)
               valid_seen++;
            if (verdict_queue.size() == 0) begin
               $display("%0t: result word with none expected, actual valid=%0b %0d.%0d.%0d",
                        $realtime, rsp_mon.is_valid, rsp_mon.major_num, rsp_mon.minor_num,
                        rsp_mon.patch_num);
               mismatches++;
            end else begin
               want = verdict_queue.pop_front();
               check_field("is_valid", 32'(want.is_valid), 32'(rsp_mon.is_valid));
               check_field("major_num", want.major_num, rsp_mon.major_num);
               check_field("minor_num", want.minor_num, rsp_mon.minor_num);
               check_field("patch_num", want.patch_num, rsp_mon.patch_num);
               check_field("has_prerelease", 32'(want.has_prerelease),
                           32'(rsp_mon.has_prerelease));
               check_field("has_build", 32'(want.has_build), 32'(rsp_mon.has_build));
            end
         end
      end
      verdicts_waiting = verdict_queue.size();
   end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench
   import svv_pkg::*;
();

   logic clock;
   logic reset;

   svv_req_if req_if ();
   svv_rsp_if rsp_if ();

   int mismatches;
   int verdicts_waiting;
   int verdicts_seen;
   int valid_seen;
   int bytes_sent;
   int strings_sent;
   bit calm;
   bit long_hold_done;

   semver_string_validator DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   semver_result_checker u_result_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_if),
      .rsp_mon          (rsp_if),
      .mismatches       (mismatches),
      .verdicts_waiting (verdicts_waiting),
      .verdicts_seen    (verdicts_seen),
      .valid_seen       (valid_seen)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial begin
      #3_600_000;
      $display("TB_ERROR");
      $finish;
   end

   // Offers one word and waits until it is taken, then maybe pauses.
   task automatic push_byte(input logic [7:0] b);
      req_if.valid <= 1'b1;
      req_if.char_byte <= b;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      bytes_sent++;
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         push_byte(s[i]);
      push_byte(CH_NUL);
      strings_sent++;
   endtask

   function automatic string rand_number();
      int unsigned v;
      v = $urandom;
      case ($urandom_range(0, 9))
         6: return $sformatf("%0d", v);
         7: return "4294967295";
         8: return $sformatf("%0d", 64'd4294967296 + 64'($urandom_range(0, 1000)));
         9: return $sformatf("0%0d", $urandom_range(0, 99));
         default: return $sformatf("%0d", $urandom_range(0, 20));
      endcase
   endfunction

   function automatic string rand_ident();
      string s;
      int n;
      s = "";
      n = $urandom_range(1, 4);
      if ($urandom_range(0, 5) == 0)
         return $sformatf("0%0d", $urandom_range(0, 9));
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 3))
            0: s = $sformatf("%s%c", s, 8'(CH_ZERO + $urandom_range(0, 9)));
            1: s = $sformatf("%s%c", s, 8'(CH_UP_A + $urandom_range(0, 25)));
            2: s = $sformatf("%s%c", s, 8'(CH_LOW_A + $urandom_range(0, 25)));
            default: s = {s, "-"};
         endcase
      end
      return s;
   endfunction

   function automatic string rand_ident_list();
      string s;
      int n;
      n = $urandom_range(1, 3);
      s = rand_ident();
      for (int i = 1; i < n; i++)
         s = {s, ".", rand_ident()};
      return s;
   endfunction

   function automatic string rand_version();
      string s;
      int pos;
      s = {rand_number(), ".", rand_number(), ".", rand_number()};
      if ($urandom_range(0, 1) == 1)
         s = {s, "-", rand_ident_list()};
      if ($urandom_range(0, 2) == 0)
         s = {s, "+", rand_ident_list()};
      // A quarter of the versions are damaged in one place.
      if ($urandom_range(0, 3) == 0) begin
         pos = $urandom_range(0, s.len() - 1);
         if ($urandom_range(0, 1) == 1)
            s[pos] = 8'($urandom_range(1, 255));
         else
            s = (pos == 0) ? "" : s.substr(0, pos - 1);
      end
      return s;
   endfunction

   function automatic string rand_noise();
      string s;
      s = "";
      repeat ($urandom_range(0, 6))
         s = $sformatf("%s%c", s, 8'($urandom_range(1, 255)));
      return s;
   endfunction

   // Receiver: random stalls, one long hold-off, and none near the end.
   initial begin
      rsp_if.ready = 1'b0;
      long_hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!long_hold_done && verdicts_seen >= 20) begin
            long_hold_done = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (300) @(posedge clock);
            rsp_if.ready <= 1'b1;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      string directed[$];
      int random_start;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.char_byte = CH_NUL;
      calm = 1'b0;
      bytes_sent = 0;
      strings_sent = 0;
      directed = '{"0.0.0", "4294967295.4294967295.4294967295", "4294967296.0.0",
                   "1.99999999999.0", "", "01.2.3", "1.2.3-", "1.2.3+", "1.2.3-a..b",
                   "1.2.3+x.", "1.2.3x", "1.2.3+a+b", "1.2.3-01", "1.2.3-0.00a.0-1",
                   "1.2.3-alpha.1+build.05", "1.0.0-azAZ09-+Zz-9", "1.0.0-a@",
                   "1.0.0+[", "1.0.0-`{", "1.0.0-/:", "1..2.3", ".1.2", "1.2",
                   "1.2.3-\377", "1.2.3+-"};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_text(directed[i]);

      // The directed strings take about 260 words; the random part fills the rest.
      random_start = bytes_sent;
      while (bytes_sent < random_start + 250) begin
         if (bytes_sent > random_start + 200)
            calm = 1'b1;
         if ($urandom_range(0, 4) == 0)
            send_text(rand_noise());
         else
            send_text(rand_version());
      end
      req_if.valid <= 1'b0;
      calm = 1'b1;

      while (verdicts_waiting != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d strings in %0d words; checked %0d results, %0d of them valid.",
               strings_sent, bytes_sent, verdicts_seen, valid_seen);
      $display("Stimulus mixed grammar edge cases, damaged versions and byte noise.");
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
